/* src/swc_pkg.sv */
package swc_pkg;

  localparam int OFFSET_BITS = 6;
  localparam int INDEX_BITS  = 4;
  localparam int WAYS        = 4;
  localparam int ADDR_BITS   = 16;

  localparam int LINE_SIZE  = 1 << OFFSET_BITS;
  localparam int SET_COUNT  = 1 << INDEX_BITS;
  localparam int SLOT_COUNT = SET_COUNT * WAYS;
  localparam int MEM_SIZE   = 1 << ADDR_BITS;
  localparam int TAG_BITS   = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int SET_BITS   = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LINE_ADDR_BITS = SLOT_BITS + OFFSET_BITS;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [1:0]  size_code;
    logic        is_instruction;
    logic [31:0] write_data;
    logic [1:0]  victim_way;
  } swc_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        wrote_back;
    logic        misfit_error;
    logic [31:0] instr_accesses;
    logic [31:0] data_accesses;
    logic [31:0] instr_hits;
    logic [31:0] data_hits;
  } swc_resp_t;

  typedef enum logic [1:0] {
    CP_NONE   = 2'd0,
    CP_SPILL  = 2'd1,
    CP_FILL   = 2'd2,
    CP_ACCESS = 2'd3
  } swc_copy_e;

  typedef struct packed {
    logic      accept;
    logic      lookup;
    swc_copy_e copy;
    logic      fill_commit;
    logic      flush_first;
    logic      flush_clear;
    logic      flush_next;
    logic      respond;
    logic      clear_step;
  } swc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_access;
    logic is_flush;
    logic hit;
    logic has_invalid;
    logic victim_dirty;
    logic copy_done;
    logic flush_dirty;
    logic flush_last;
    logic out_busy;
  } swc_status_t;

endpackage

/* src/swc_ctrl.sv */
module swc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swc_pkg::swc_status_t status_i,
  output swc_pkg::swc_cmd_t    cmd_o
);
  import swc_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOKUP = 9'b000000100,
    S_SPILL  = 9'b000001000,
    S_FILL   = 9'b000010000,
    S_ACCESS = 9'b000100000,
    S_FLUSH  = 9'b001000000,
    S_FSPILL = 9'b010000000,
    S_DONE   = 9'b100000000
  } swc_state_e;

  swc_state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.copy = CP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        priority if (status_i.is_access) begin
          cmd_o.lookup = 1'b1;
          priority if (status_i.hit) state_d = S_ACCESS;
          else if (status_i.has_invalid) state_d = S_FILL;
          else if (status_i.victim_dirty) state_d = S_SPILL;
          else state_d = S_FILL;
        end else if (status_i.is_flush) begin
          cmd_o.flush_first = 1'b1;
          state_d = S_FLUSH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SPILL: begin
        cmd_o.copy = CP_SPILL;
        if (status_i.copy_done) state_d = S_FILL;
      end
      S_FILL: begin
        cmd_o.copy = CP_FILL;
        if (status_i.copy_done) begin
          cmd_o.fill_commit = 1'b1;
          state_d = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd_o.copy = CP_ACCESS;
        if (status_i.copy_done) state_d = S_DONE;
      end
      S_FLUSH: begin
        priority if (status_i.flush_dirty) begin
          state_d = S_FSPILL;
        end else begin
          cmd_o.flush_next = 1'b1;
          if (status_i.flush_last) state_d = S_DONE;
        end
      end
      S_FSPILL: begin
        cmd_o.copy = CP_SPILL;
        if (status_i.copy_done) begin
          cmd_o.flush_clear = 1'b1;
          cmd_o.flush_next  = 1'b1;
          state_d = status_i.flush_last ? S_DONE : S_FLUSH;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.respond = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/swc_dp.sv */
module swc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swc_pkg::swc_req_t    req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output swc_pkg::swc_resp_t   resp_o,
  input  swc_pkg::swc_cmd_t    cmd_i,
  output swc_pkg::swc_status_t status_o
);
  import swc_pkg::*;

  logic [7:0] line_mem [SLOT_COUNT * LINE_SIZE];
  logic [7:0] back_mem [MEM_SIZE];

  // one entry per set, all ways of the set side by side
  logic [WAYS-1:0][TAG_BITS-1:0] tag_q [SET_COUNT];
  logic [WAYS-1:0]     valid_q [SET_COUNT];
  logic [WAYS-1:0]     dirty_q [SET_COUNT];

  swc_req_t  req_q;
  swc_resp_t resp_q;
  logic      out_valid_q;
  logic [31:0] rdata_q;
  logic      hit_q, wb_q;
  logic [WAY_BITS-1:0] way_q;
  logic [31:0] iacc_q, dacc_q, ihit_q, dhit_q;
  logic [SET_BITS-1:0] fl_set_q;
  logic [WAY_BITS-1:0] fl_way_q;
  logic [ADDR_BITS-1:0] clr_q;
  logic [OFFSET_BITS:0]   cp_cnt_q;
  logic                   cp_pend_q;
  logic [OFFSET_BITS-1:0] cp_idx_q;
  logic [7:0] line_rdata_q, back_rdata_q;

  // request decode
  logic [ADDR_BITS-1:0]   addr;
  logic [OFFSET_BITS-1:0] off;
  logic [SET_BITS-1:0]    req_set;
  logic [TAG_BITS-1:0]    req_tag;
  logic [1:0]             size_sat;
  logic [2:0]             nbytes;
  logic                   misfit, is_rw, is_flush, is_instr;

  assign addr     = ADDR_BITS'(req_q.address);
  assign off      = addr[OFFSET_BITS-1:0];
  assign req_set  = SET_BITS'((addr >> OFFSET_BITS) & ADDR_BITS'(SET_COUNT - 1));
  assign req_tag  = TAG_BITS'(addr >> (OFFSET_BITS + INDEX_BITS));
  assign size_sat = (req_q.size_code > 2'd2) ? 2'd2 : req_q.size_code;
  assign nbytes   = (size_sat == SIZE_BYTE) ? 3'd1 : ((size_sat == SIZE_HALF) ? 3'd2 : 3'd4);
  assign misfit   = ((OFFSET_BITS+1)'(off) + (OFFSET_BITS+1)'(nbytes))
                    > (OFFSET_BITS+1)'(LINE_SIZE);
  assign is_rw    = (req_q.func == FUNC_READ) || (req_q.func == FUNC_WRITE);
  assign is_flush = (req_q.func == FUNC_FLUSH);
  assign is_instr = (req_q.func == FUNC_READ) && req_q.is_instruction;

  // set lookup
  logic [SET_BITS-1:0] cur_set;
  logic [WAY_BITS-1:0] cur_way, hit_way, inv_way, vic_way, pick_way;
  logic                hit_found, inv_found;
  logic [SLOT_BITS-1:0] slot;
  logic [TAG_BITS-1:0]  slot_tag;
  logic [2:0]           vic_tmp;

  assign cur_set = is_flush ? fl_set_q : req_set;

  always_comb begin
    hit_found = 1'b0;
    inv_found = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_found && valid_q[cur_set][w] && tag_q[cur_set][w] == req_tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_BITS'(w);
      end
      if (!inv_found && !valid_q[cur_set][w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_BITS'(w);
      end
    end
    vic_tmp = {1'b0, req_q.victim_way};
    for (int k = 0; k < 3; k++) begin
      if (int'(vic_tmp) >= WAYS) vic_tmp = vic_tmp - 3'(WAYS);
    end
    vic_way = WAY_BITS'(vic_tmp);
  end

  assign pick_way = hit_found ? hit_way : (inv_found ? inv_way : vic_way);
  assign cur_way  = is_flush ? fl_way_q : way_q;
  assign slot     = SLOT_BITS'(int'(cur_set) * WAYS + int'(cur_way));
  assign slot_tag = tag_q[cur_set][cur_way];

  // byte move engine
  logic [OFFSET_BITS-1:0] cp_end, acc_rd, acc_wr;
  logic cp_active, cp_issue, cp_done;

  assign cp_active = (cmd_i.copy != CP_NONE);
  assign cp_end    = (cmd_i.copy == CP_ACCESS) ? OFFSET_BITS'(nbytes - 3'd1) : '1;
  assign cp_issue  = cp_active && (cp_cnt_q <= (OFFSET_BITS+1)'(cp_end));
  assign cp_done   = cp_active && cp_pend_q && (cp_idx_q == cp_end);
  assign acc_rd    = off + cp_cnt_q[OFFSET_BITS-1:0];
  assign acc_wr    = off + cp_idx_q;

  logic [LINE_ADDR_BITS-1:0] line_raddr, line_waddr;
  logic [ADDR_BITS-1:0]      back_raddr, back_waddr;
  logic [7:0]                line_wdata, back_wdata;
  logic                      line_we, back_we;

  always_comb begin
    line_raddr = {slot, (cmd_i.copy == CP_ACCESS) ? acc_rd : cp_cnt_q[OFFSET_BITS-1:0]};
    back_raddr = ADDR_BITS'({req_tag, cur_set, cp_cnt_q[OFFSET_BITS-1:0]});
    line_we    = 1'b0;
    line_waddr = {slot, cp_idx_q};
    line_wdata = back_rdata_q;
    back_we    = 1'b0;
    back_waddr = ADDR_BITS'({slot_tag, cur_set, cp_idx_q});
    back_wdata = line_rdata_q;
    if (cmd_i.clear_step) begin
      back_we    = 1'b1;
      back_waddr = clr_q;
      back_wdata = '0;
    end else if (cp_pend_q) begin
      unique case (cmd_i.copy)
        CP_SPILL: back_we = 1'b1;
        CP_FILL:  line_we = 1'b1;
        CP_ACCESS: begin
          line_we    = (req_q.func == FUNC_WRITE);
          line_waddr = {slot, acc_wr};
          line_wdata = req_q.write_data[8*cp_idx_q[1:0] +: 8];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_waddr] <= line_wdata;
    line_rdata_q <= line_mem[line_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (back_we) back_mem[back_waddr] <= back_wdata;
    back_rdata_q <= back_mem[back_raddr];
  end

  // tags and payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
    if (cmd_i.fill_commit) tag_q[cur_set][cur_way] <= req_tag;
    if (cmd_i.lookup) way_q <= pick_way;
    if (cmd_i.accept) rdata_q <= '0;
    else if (cmd_i.copy == CP_ACCESS && cp_pend_q && req_q.func == FUNC_READ)
      rdata_q[8*cp_idx_q[1:0] +: 8] <= line_rdata_q;
    if (cmd_i.respond) begin
      resp_q.read_data      <= rdata_q;
      resp_q.hit            <= hit_q;
      resp_q.wrote_back     <= wb_q;
      resp_q.misfit_error   <= is_rw && misfit;
      resp_q.instr_accesses <= iacc_q;
      resp_q.data_accesses  <= dacc_q;
      resp_q.instr_hits     <= ihit_q;
      resp_q.data_hits      <= dhit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        valid_q[s] <= '0;
        dirty_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      wb_q        <= 1'b0;
      iacc_q      <= '0;
      dacc_q      <= '0;
      ihit_q      <= '0;
      dhit_q      <= '0;
      fl_set_q    <= '0;
      fl_way_q    <= '0;
      clr_q       <= '0;
      cp_cnt_q    <= '0;
      cp_pend_q   <= 1'b0;
      cp_idx_q    <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.accept) begin
        hit_q <= 1'b0;
        wb_q  <= 1'b0;
      end
      if (cmd_i.lookup) begin
        hit_q <= hit_found;
        if (is_instr) iacc_q <= iacc_q + 1'b1;
        else          dacc_q <= dacc_q + 1'b1;
        if (hit_found && is_instr)  ihit_q <= ihit_q + 1'b1;
        if (hit_found && !is_instr) dhit_q <= dhit_q + 1'b1;
      end
      if (cp_done && cmd_i.copy == CP_SPILL) wb_q <= 1'b1;
      if (cmd_i.fill_commit) begin
        valid_q[cur_set][cur_way] <= 1'b1;
        dirty_q[cur_set][cur_way] <= 1'b0;
      end
      if (cp_done && cmd_i.copy == CP_ACCESS && req_q.func == FUNC_WRITE)
        dirty_q[cur_set][cur_way] <= 1'b1;
      if (cmd_i.flush_clear) dirty_q[cur_set][cur_way] <= 1'b0;
      if (cmd_i.flush_first) begin
        fl_set_q <= '0;
        fl_way_q <= '0;
      end else if (cmd_i.flush_next) begin
        if (int'(fl_way_q) == WAYS - 1) begin
          fl_way_q <= '0;
          fl_set_q <= fl_set_q + 1'b1;
        end else begin
          fl_way_q <= fl_way_q + 1'b1;
        end
      end
      // byte move pipeline: read issued in the cycle before its write
      if (cp_done || !cp_active) begin
        cp_cnt_q  <= '0;
        cp_pend_q <= 1'b0;
      end else begin
        cp_pend_q <= cp_issue;
        cp_idx_q  <= cp_cnt_q[OFFSET_BITS-1:0];
        if (cp_issue) cp_cnt_q <= cp_cnt_q + 1'b1;
      end
      if (cmd_i.respond) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign resp_o      = resp_q;

  always_comb begin
    status_o              = '0;
    status_o.clear_done   = (clr_q == '1);
    status_o.is_access    = is_rw && !misfit;
    status_o.is_flush     = is_flush;
    status_o.hit          = hit_found;
    status_o.has_invalid  = inv_found;
    status_o.victim_dirty = dirty_q[cur_set][vic_way];
    status_o.copy_done    = cp_done;
    status_o.flush_dirty  = valid_q[fl_set_q][fl_way_q] && dirty_q[fl_set_q][fl_way_q];
    status_o.flush_last   = (int'(fl_set_q) == SET_COUNT - 1) && (int'(fl_way_q) == WAYS - 1);
    status_o.out_busy     = out_valid_q && out_stall_i;
  end

endmodule

/* src/set_assoc_writeback_cache_top.sv */
// set-associative write-back write-allocate cache with its own backing memory
// input channel: in_valid_i / in_stall_o carry one request beat (read, write
// or flush); output channel: out_valid_o / out_stall_i carry one result beat
// per request, in order
// a beat moves at a clock edge with valid high and stall low
// one request is in work at a time; in_stall_o is low only while idle
// a hit goes through accept, tag lookup, the access moving one byte per cycle
// through the line store port, then the result register
// a miss adds a line fill, and before it a spill of a dirty victim, each
// through the single byte-wide port of each memory
// a flush visits every slot once and writes back each dirty line it finds
// after reset the backing memory is cleared one byte per cycle, with
// in_stall_o held high
// a result waiting under out_stall_i does not block the next request; only
// the following result waits for the output register to free up
module set_assoc_writeback_cache_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  swc_pkg::swc_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output swc_pkg::swc_resp_t out_data_o
);
  import swc_pkg::*;

  swc_cmd_t    cmd;
  swc_status_t status;

  // sequencing of lookup, spill, fill, access and flush sweep
  swc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // tags, line store, backing memory, counters and result register
  swc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .resp_o      (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
